// ===== src/fmp_pkg.sv =====
// package: types, microcode and constants for the fibonacci matrix power block
`timescale 1ns / 1ps

package fmp_pkg;

  localparam int INDEX_BITS_DEF = 8;
  localparam int VALUE_BITS_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    MUL_AA,
    MUL_BB,
    MUL_DD,
    MUL_BS
  } mul_sel_t;

  typedef enum logic [1:0] {
    TMP_HOLD,
    TMP_LOAD,
    TMP_ADD
  } tmp_op_t;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_BIT,
    SEQ_LOOP
  } seq_op_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_p;
    tmp_op_t  t0_op;
    tmp_op_t  t1_op;
    logic     ld_s;
    logic     wr_sq;
    logic     wr_base;
    seq_op_t  seq;
  } uword_t;

  localparam int UPC_BITS = 3;

  localparam uword_t UW_IDLE = '{MUL_AA, 1'b0, TMP_HOLD, TMP_HOLD, 1'b0, 1'b0, 1'b0, SEQ_LOOP};

  // squaring of the symmetric power [[a,b],[b,d]], then optional multiply by the base
  function automatic uword_t ucode_at(input logic [UPC_BITS-1:0] upc);
    uword_t w;
    w = UW_IDLE;
    unique case (upc)
      3'd0: w = '{MUL_AA, 1'b1, TMP_HOLD, TMP_HOLD, 1'b1, 1'b0, 1'b0, SEQ_NEXT};
      3'd1: w = '{MUL_BB, 1'b1, TMP_LOAD, TMP_HOLD, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
      3'd2: w = '{MUL_DD, 1'b1, TMP_ADD,  TMP_LOAD, 1'b0, 1'b0, 1'b0, SEQ_NEXT};
      3'd3: w = '{MUL_BS, 1'b1, TMP_HOLD, TMP_ADD,  1'b0, 1'b0, 1'b0, SEQ_NEXT};
      3'd4: w = '{MUL_AA, 1'b0, TMP_HOLD, TMP_HOLD, 1'b0, 1'b1, 1'b0, SEQ_BIT};
      3'd5: w = '{MUL_AA, 1'b0, TMP_HOLD, TMP_HOLD, 1'b0, 1'b0, 1'b1, SEQ_LOOP};
      default: w = UW_IDLE;
    endcase
    return w;
  endfunction

  // smallest index whose true fibonacci number needs more than vbits bits
  function automatic int first_too_big(input int vbits);
    logic [67:0] a;
    logic [67:0] b;
    logic [67:0] c;
    logic [67:0] lim;
    int          res;
    logic        found;
    a     = '0;
    b     = 68'd1;
    lim   = (68'd1 << vbits) - 68'd1;
    res   = 0;
    found = 1'b0;
    for (int i = 0; i < 128; i++) begin
      if (!found && (a > lim)) begin
        res   = i;
        found = 1'b1;
      end
      c = a + b;
      a = b;
      b = c;
    end
    return res;
  endfunction

endpackage

// ===== src/fmp_if.sv =====
// channel interfaces: index input and fibonacci result output
`timescale 1ns / 1ps

interface fmp_in_if #(
  parameter int INDEX_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic [INDEX_BITS-1:0] index;

  modport source (output valid, output index, input ready);
  modport sink (input valid, input index, output ready);
endinterface

interface fmp_out_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink (input valid, input value, input overflow, output ready);
endinterface

// ===== src/fibonacci_matrix_power.sv =====
// top level: fibonacci number by microcoded matrix square-and-multiply
// Usage: an item on in_chan carries an index n; its result then appears on
// out_chan with F(n) modulo 2^VALUE_BITS and an overflow flag that is set
// when the true F(n) needs more than VALUE_BITS bits. Both channels use a
// valid/ready handshake. One index is in work at a time; in_chan.ready is
// high while the engine is idle. The engine walks the bits of n-1 below the
// leading one, each taking a squaring on a single shared multiplier plus a
// multiply by the base when the bit is set; for n below 3 there is no walk.
// A finished result sits in an output register, so a new index is taken
// while it waits; if the receiver stalls, the next result is held in the
// engine until the output register frees. Reset (rst_n low, synchronous)
// empties the engine and the output register.
`timescale 1ns / 1ps

module fibonacci_matrix_power #(
  parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF,
  parameter int VALUE_BITS = fmp_pkg::VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  fmp_in_if.sink        in_chan,
  fmp_out_if.source     out_chan
);
  import fmp_pkg::*;

  localparam int BW  = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;
  localparam int CW  = INDEX_BITS + 8;
  localparam logic [CW-1:0] OVF_THRESH = CW'(first_too_big(VALUE_BITS));

  state_t                state_r;
  state_t                state_nxt;
  logic [UPC_BITS-1:0]   upc_r;
  logic [BW-1:0]         bidx_r;
  logic [INDEX_BITS-1:0] exp_r;
  logic                  zero_r;
  logic                  ovf_r;

  logic [VALUE_BITS-1:0] a_r;
  logic [VALUE_BITS-1:0] b_r;
  logic [VALUE_BITS-1:0] d_r;
  logic [VALUE_BITS-1:0] s_r;
  logic [VALUE_BITS-1:0] p_r;
  logic [VALUE_BITS-1:0] t0_r;
  logic [VALUE_BITS-1:0] t1_r;

  logic                  out_valid_r;
  logic [VALUE_BITS-1:0] out_value_r;
  logic                  out_ovf_r;

  uword_t                uw;
  logic                  in_acc;
  logic [INDEX_BITS-1:0] exp_in;
  logic [BW-1:0]         top_in;
  logic                  start_run;
  logic                  ovf_in;
  logic [VALUE_BITS-1:0] op_x;
  logic [VALUE_BITS-1:0] op_y;
  logic [2*VALUE_BITS-1:0] prod_full;
  logic                  cur_bit;
  logic                  loop_end;
  logic                  take_bit;
  logic                  out_free;

  assign in_chan.ready     = (state_r == ST_IDLE);
  assign in_acc            = in_chan.valid && in_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.value    = out_value_r;
  assign out_chan.overflow = out_ovf_r;
  assign out_free          = !out_valid_r || out_chan.ready;

  // exponent and its leading one
  assign exp_in = in_chan.index - INDEX_BITS'(1);
  always_comb begin
    top_in = '0;
    for (int i = 0; i < INDEX_BITS; i++) begin
      if (exp_in[i]) top_in = BW'(i);
    end
  end
  assign start_run = (in_chan.index != '0) && (top_in != '0);
  assign ovf_in    = ({{(CW-INDEX_BITS){1'b0}}, in_chan.index} >= OVF_THRESH);

  assign uw = ucode_at(upc_r);

  always_comb begin
    unique case (uw.mul_sel)
      MUL_AA: begin
        op_x = a_r;
        op_y = a_r;
      end
      MUL_BB: begin
        op_x = b_r;
        op_y = b_r;
      end
      MUL_DD: begin
        op_x = d_r;
        op_y = d_r;
      end
      MUL_BS: begin
        op_x = b_r;
        op_y = s_r;
      end
      default: begin
        op_x = a_r;
        op_y = a_r;
      end
    endcase
  end
  assign prod_full = op_x * op_y;

  assign cur_bit  = exp_r[bidx_r];
  assign take_bit = (uw.seq == SEQ_BIT) && cur_bit;
  assign loop_end = (state_r == ST_RUN) && !take_bit &&
                    ((uw.seq == SEQ_BIT) || (uw.seq == SEQ_LOOP)) && (bidx_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = start_run ? ST_RUN : ST_HOLD;
      ST_RUN:  if (loop_end) state_nxt = ST_HOLD;
      ST_HOLD: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      upc_r       <= '0;
      bidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        upc_r  <= '0;
        bidx_r <= top_in - BW'(1);
      end else if (state_r == ST_RUN) begin
        priority if (take_bit) begin
          upc_r <= upc_r + UPC_BITS'(1);
        end else if ((uw.seq == SEQ_BIT) || (uw.seq == SEQ_LOOP)) begin
          upc_r <= '0;
          if (bidx_r != '0) bidx_r <= bidx_r - BW'(1);
        end else begin
          upc_r <= upc_r + UPC_BITS'(1);
        end
      end
      if (state_r == ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r    <= VALUE_BITS'(1);
      b_r    <= VALUE_BITS'(1);
      d_r    <= '0;
      exp_r  <= exp_in;
      zero_r <= (in_chan.index == '0);
      ovf_r  <= ovf_in;
    end else if (state_r == ST_RUN) begin
      if (uw.ld_p) p_r <= prod_full[VALUE_BITS-1:0];
      if (uw.ld_s) s_r <= a_r + d_r;
      unique case (uw.t0_op)
        TMP_LOAD: t0_r <= p_r;
        TMP_ADD:  t0_r <= t0_r + p_r;
        default:  t0_r <= t0_r;
      endcase
      unique case (uw.t1_op)
        TMP_LOAD: t1_r <= p_r;
        TMP_ADD:  t1_r <= t1_r + p_r;
        default:  t1_r <= t1_r;
      endcase
      if (uw.wr_sq) begin
        a_r <= t0_r;
        b_r <= p_r;
        d_r <= t1_r;
      end else if (uw.wr_base) begin
        a_r <= a_r + b_r;
        b_r <= a_r;
        d_r <= b_r;
      end
    end
    if (state_r == ST_HOLD && out_free) begin
      out_value_r <= zero_r ? '0 : a_r;
      out_ovf_r   <= ovf_r;
    end
  end

endmodule

// ===== dv/fibonacci_matrix_power_tb.sv =====
// testbench: fibonacci matrix power checked item by item against typed directed values or a local fibonacci predictor
`timescale 1ns / 1ps

module fibonacci_matrix_power_tb;

  localparam int IB = fmp_pkg::INDEX_BITS_DEF;
  localparam int VB = fmp_pkg::VALUE_BITS_DEF;
  localparam int RANDOM_ITEMS = 1525;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 60;
  localparam int LONG_HOLD = 200;
  localparam int MAX_PRINTS = 100;

  typedef struct packed {
    logic [IB-1:0] index;
    logic          typed;
    logic [VB-1:0] value;
    logic          overflow;
  } fib_row_t;

  typedef struct {
    logic [IB-1:0] index;
    logic [VB-1:0] value;
    logic          overflow;
  } fib_result_t;

  // extremes, small indices, the overflow boundary, indices around powers of two and alternating bit patterns
  localparam int N_DIRECTED = 25;
  localparam fib_row_t DIRECTED [N_DIRECTED] = '{
    '{8'd0,   1'b1, 32'd0,          1'b0},
    '{8'd1,   1'b1, 32'd1,          1'b0},
    '{8'd2,   1'b1, 32'd1,          1'b0},
    '{8'd3,   1'b1, 32'd2,          1'b0},
    '{8'd4,   1'b1, 32'd3,          1'b0},
    '{8'd5,   1'b1, 32'd5,          1'b0},
    '{8'd7,   1'b1, 32'd13,         1'b0},
    '{8'd8,   1'b1, 32'd21,         1'b0},
    '{8'd9,   1'b1, 32'd34,         1'b0},
    '{8'd16,  1'b0, 32'd0,          1'b0},
    '{8'd17,  1'b0, 32'd0,          1'b0},
    '{8'd32,  1'b0, 32'd0,          1'b0},
    '{8'd33,  1'b0, 32'd0,          1'b0},
    '{8'd47,  1'b1, 32'd2971215073, 1'b0},
    '{8'd48,  1'b1, 32'd512559680,  1'b1},
    '{8'd49,  1'b0, 32'd0,          1'b0},
    '{8'd64,  1'b0, 32'd0,          1'b0},
    '{8'd65,  1'b0, 32'd0,          1'b0},
    '{8'd127, 1'b0, 32'd0,          1'b0},
    '{8'd128, 1'b0, 32'd0,          1'b0},
    '{8'd129, 1'b0, 32'd0,          1'b0},
    '{8'd170, 1'b0, 32'd0,          1'b0},
    '{8'd85,  1'b0, 32'd0,          1'b0},
    '{8'd254, 1'b0, 32'd0,          1'b0},
    '{8'd255, 1'b0, 32'd0,          1'b0}
  };

  logic clk;
  logic rst_n;

  fmp_in_if #(.INDEX_BITS(IB)) in_ch ();
  fmp_out_if #(.VALUE_BITS(VB)) out_ch ();

  fibonacci_matrix_power #(
    .INDEX_BITS(IB),
    .VALUE_BITS(VB)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch)
  );

  fib_result_t fib_pending[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;
  int          long_hold = 0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL fibonacci_matrix_power");
      $finish;
    end
  end

  // F(n) modulo 2^VB, plus whether the true F(n) needs more than VB bits
  function automatic fib_result_t fib_of(input logic [IB-1:0] n);
    fib_result_t     r;
    logic [VB-1:0]   lo_a;
    logic [VB-1:0]   lo_b;
    logic [VB-1:0]   lo_t;
    longint unsigned true_a;
    longint unsigned true_b;
    longint unsigned true_t;
    longint unsigned cap;
    cap    = 64'd1 << VB;
    lo_a   = '0;
    lo_b   = VB'(1);
    true_a = 64'd0;
    true_b = 64'd1;
    for (int i = 0; i < n; i++) begin
      lo_t   = lo_a + lo_b;
      lo_a   = lo_b;
      lo_b   = lo_t;
      true_t = true_a + true_b;
      if (true_t > cap) begin
        true_t = cap;
      end
      true_a = true_b;
      true_b = true_t;
    end
    r.index    = n;
    r.value    = lo_a;
    r.overflow = (true_a >= cap);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [IB-1:0] n,
                                 input longint unsigned got, input longint unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch at cycle %0d: %s for index %0d: got %0d, expected %0d",
               cycle_count, what, n, got, want);
    end
  endtask

  task automatic send_index(input logic [IB-1:0] n, input fib_row_t row);
    int          gap;
    fib_result_t want;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      in_ch.index <= IB'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.index <= n;
    do @(posedge clk); while (!in_ch.ready);
    if (row.typed) begin
      want.index    = n;
      want.value    = row.value;
      want.overflow = row.overflow;
    end else begin
      want = fib_of(n);
    end
    fib_pending.push_back(want);
  endtask

  // result side: random stall per item, one long hold-off on request
  initial begin
    int          stall;
    fib_result_t want;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_hold > 0) begin
        stall     = long_hold;
        long_hold = 0;
      end else begin
        stall = idle_on ? $urandom_range(0, 5) : 0;
      end
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (fib_pending.size() == 0) begin
        report_mismatch("unexpected result value", '0, 64'(out_ch.value), 64'd0);
      end else begin
        want = fib_pending.pop_front();
        if (out_ch.value !== want.value) begin
          report_mismatch("value", want.index, 64'(out_ch.value), 64'(want.value));
        end
        if (out_ch.overflow !== want.overflow) begin
          report_mismatch("overflow", want.index, 64'(out_ch.overflow),
                          64'(want.overflow));
        end
      end
    end
  end

  initial begin
    fib_row_t      no_row;
    logic [IB-1:0] n;
    no_row      = '0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.index = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_index(DIRECTED[i].index, DIRECTED[i]);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // no idling on either side for a stretch
      if (i == 300) begin
        idle_on = 1'b0;
      end
      if (i == 500) begin
        idle_on = 1'b1;
      end
      // receiver holds off while the sender keeps offering
      if (i == 700) begin
        long_hold = LONG_HOLD;
      end
      // sender drains everything before going on
      if (i == 1000) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        wait (fib_pending.size() == 0);
      end
      if ($urandom_range(0, 3) == 0) begin
        n = IB'($urandom_range(0, 60));
      end else begin
        n = IB'($urandom_range(0, (1 << IB) - 1));
      end
      send_index(n, no_row);
    end
    @(negedge clk);
    in_ch.valid <= 1'b0;

    wait (fib_pending.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && fib_pending.size() == 0) begin
      $display("PASS fibonacci_matrix_power");
    end else begin
      $display("FAIL fibonacci_matrix_power");
    end
    $finish;
  end

endmodule
